/* src/kmv_pkg.sv */
// ----------------------------------------------------------------------------
// kmv_pkg
// Shared types and constants for the k-minimum-values sketch update block.
// ----------------------------------------------------------------------------
package kmv_pkg;

  // Default sketch capacity (entries held at most)
  localparam int unsigned KMV_MAX_K = 64;

  // Fixed field widths
  localparam int unsigned HASH_W = 64;
  localparam int unsigned KLIM_W = 7;
  localparam int unsigned FILL_W = 7;

  // Result word: 138 payload bits padded to whole bytes
  localparam int unsigned RES_W  = 3 + HASH_W + FILL_W + HASH_W;
  localparam int unsigned RES_BW = ((RES_W + 7) / 8) * 8;

  // Default k_limit after reset
  localparam logic [KLIM_W-1:0] KLIM_RESET = KLIM_W'(64);

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_WAIT = 4'b0100,
    S_DONE = 4'b1000
  } kmv_state_t;

  // Status gathered over one pass of the held entries
  typedef struct packed {
    logic              dup;     // key matched a held entry
    logic [HASH_W-1:0] second;  // largest entry other than the current max
  } kmv_scan_t;

endpackage

/* src/kmv_sketch_update.sv */
// ----------------------------------------------------------------------------
// kmv_sketch_update
// Keeps the k smallest distinct 64-bit hash values seen since reset.
//
//   Channel  Direction  Handshake                 Payload
//   s_*      in         s_tvalid / s_tready       hash_value
//   m_*      out        m_tvalid / m_tready       one result per hash
//   cfg_*    in         cfg_valid / cfg_ready     k_limit
//
// After a hash is accepted, the scan state reads all held entries one slot
// per cycle through a single compare unit, then the wait and done states
// follow; an empty sketch goes straight to done. s_tready is high
// only in idle, entered as the result is registered. A waiting result sits in
// the output register, so the next hash is taken while it is stalled. No
// clearing pass after reset; cfg_ready is always high.
// ----------------------------------------------------------------------------
module kmv_sketch_update
  import kmv_pkg::*;
#(
  parameter int unsigned MAX_K = KMV_MAX_K
) (
  input  logic              clk,
  input  logic              rst,
  // hash input: [63:0] hash_value
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [HASH_W-1:0] s_tdata,
  // result: [0] taken, [1] duplicate, [2] evicted_valid,
  // [66:3] evicted_value, [73:67] fill_count, [137:74] threshold, rest zero
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [RES_BW-1:0] m_tdata,
  // k_limit write: [6:0] k_limit
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [KLIM_W-1:0] cfg_data
);

  localparam int unsigned AW   = $clog2(MAX_K);
  localparam int unsigned CW   = $clog2(MAX_K + 1);
  localparam int unsigned CMPW = (CW > KLIM_W) ? CW : KLIM_W;

  kmv_state_t        state;
  logic [KLIM_W-1:0] k_limit;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     rd_idx;
  logic [HASH_W-1:0] key;
  logic [HASH_W-1:0] cur_max;

  logic              s_fire;
  logic              done_fire;
  logic              rd_en;
  logic              we;
  logic [AW-1:0]     wr_addr;
  logic [CMPW-1:0]   k_eff;
  logic              room;
  logic              do_add;
  logic              do_evict;
  logic [HASH_W-1:0] new_max;
  logic [HASH_W-1:0] rd_data;
  logic [AW-1:0]     max_idx;
  kmv_scan_t         scan_res;
  logic [RES_BW-1:0] res_word;

  assign s_tready  = (state == S_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign done_fire = (state == S_DONE) && (!m_tvalid || m_tready);
  assign rd_en     = (state == S_SCAN);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      k_limit <= KLIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      k_limit <= cfg_data;
    end
  end

  // effective k: zero means one, saturate at capacity
  always_comb begin
    k_eff = CMPW'(k_limit);
    if (k_limit == '0) begin
      k_eff = CMPW'(1);
    end
    if (k_eff > CMPW'(MAX_K)) begin
      k_eff = CMPW'(MAX_K);
    end
  end

  // decision on the scan outcome
  always_comb begin
    room     = CMPW'(cnt) < k_eff;
    do_add   = !scan_res.dup && room;
    do_evict = !scan_res.dup && !room && (cnt != '0) && (key < cur_max);
    new_max  = (key > scan_res.second) ? key : scan_res.second;
    we       = done_fire && (do_add || do_evict);
    wr_addr  = do_add ? cnt[AW-1:0] : max_idx;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            state <= (cnt == '0) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_idx + CW'(1) == cnt) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (done_fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // scan address and captured key
  always_ff @(posedge clk) begin
    if (s_fire) begin
      key    <= s_tdata;
      rd_idx <= '0;
    end else if (rd_en) begin
      rd_idx <= rd_idx + CW'(1);
    end
  end

  // sketch fill and maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      cur_max <= '0;
    end else if (done_fire) begin
      if (do_add) begin
        cnt <= cnt + CW'(1);
        if (cnt == '0 || key > cur_max) begin
          cur_max <= key;
        end
      end else if (do_evict) begin
        cur_max <= new_max;
      end
    end
  end

  // result word
  always_comb begin
    res_word          = '0;
    res_word[0]       = do_add || do_evict;
    res_word[1]       = scan_res.dup;
    res_word[2]       = do_evict;
    res_word[66:3]    = do_evict ? cur_max : '0;
    if (do_add) begin
      res_word[73:67] = FILL_W'(cnt + CW'(1));
    end else begin
      res_word[73:67] = FILL_W'(cnt);
    end
    if (do_add) begin
      res_word[137:74] = (cnt == '0 || key > cur_max) ? key : cur_max;
    end else if (do_evict) begin
      res_word[137:74] = new_max;
    end else begin
      res_word[137:74] = cur_max;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      m_tdata <= res_word;
    end
  end

  kmv_store #(
    .MAX_K (MAX_K),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (key),
    .re      (rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  kmv_scan #(
    .MAX_K (MAX_K),
    .AW    (AW)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .clr     (s_fire),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data),
    .key     (key),
    .cur_max (cur_max),
    .res     (scan_res),
    .max_idx (max_idx)
  );

endmodule

/* src/kmv_store.sv */
// ----------------------------------------------------------------------------
// kmv_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kmv_store
  import kmv_pkg::*;
#(
  parameter int unsigned MAX_K = KMV_MAX_K,
  parameter int unsigned AW    = $clog2(MAX_K)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     wr_addr,
  input  logic [HASH_W-1:0] wr_data,
  input  logic              re,
  input  logic [AW-1:0]     rd_addr,
  output logic [HASH_W-1:0] rd_data
);

  logic [HASH_W-1:0] mem [MAX_K];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/kmv_scan.sv */
// ----------------------------------------------------------------------------
// kmv_scan
// Compare unit stepped over the held entries, one entry per cycle: flags a
// duplicate, finds the slot of the current max and tracks the runner-up.
// ----------------------------------------------------------------------------
module kmv_scan
  import kmv_pkg::*;
#(
  parameter int unsigned MAX_K = KMV_MAX_K,
  parameter int unsigned AW    = $clog2(MAX_K)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clr,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  input  logic [HASH_W-1:0] rd_data,
  input  logic [HASH_W-1:0] key,
  input  logic [HASH_W-1:0] cur_max,
  output kmv_scan_t         res,
  output logic [AW-1:0]     max_idx
);

  logic          en_q;
  logic [AW-1:0] idx_q;

  // align the read request with the registered memory data
  always_ff @(posedge clk) begin
    if (rst) begin
      en_q <= 1'b0;
    end else begin
      en_q <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    idx_q <= rd_addr;
  end

  // accumulate compare results over the pass
  always_ff @(posedge clk) begin
    if (clr) begin
      res.dup    <= 1'b0;
      res.second <= '0;
    end else if (en_q) begin
      if (rd_data == key) begin
        res.dup <= 1'b1;
      end
      if (rd_data == cur_max) begin
        max_idx <= idx_q;
      end else if (rd_data > res.second) begin
        res.second <= rd_data;
      end
    end
  end

endmodule

/* tb/kmv_sketch_update_tb.sv */
// ----------------------------------------------------------------------------
// kmv_sketch_update_tb
// Self-checking bench for the k-minimum-values sketch update block. A clocked
// driver feeds hash values from a pending queue, and a functional model of the
// sketch predicts each result on acceptance. A clocked monitor compares every
// result transaction, field by field, against the oldest prediction. k_limit
// is rewritten between phases, once the block has drained.
// ----------------------------------------------------------------------------
module kmv_sketch_update_tb;
  import kmv_pkg::*;

  // Result fields, lowest bit last
  typedef struct packed {
    logic [HASH_W-1:0] threshold;
    logic [FILL_W-1:0] fill_count;
    logic [HASH_W-1:0] evicted_value;
    logic              evicted_valid;
    logic              duplicate;
    logic              taken;
  } outcome_t;

  localparam int IDLE_PCT       = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE         = KMV_MAX_K + 8;
  localparam int RAND_PER_PHASE = 40;
  localparam int HISTORY_DEPTH  = 128;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [HASH_W-1:0] s_tdata   = '0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [RES_BW-1:0] m_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [KLIM_W-1:0] cfg_data  = '0;

  // Pending hashes, predicted outcomes, recently sent values
  logic [HASH_W-1:0] hash_queue[$];
  outcome_t          outcome_queue[$];
  logic [HASH_W-1:0] sent_history[$];

  // Sketch model state
  logic [HASH_W-1:0] held [KMV_MAX_K];
  int                held_count = 0;
  logic [HASH_W-1:0] held_max   = '0;
  logic [KLIM_W-1:0] k_setting  = KLIM_RESET;

  // Bookkeeping
  int hashes_queued   = 0;
  int hashes_accepted = 0;
  int results_seen    = 0;
  int mismatch_count  = 0;
  int settings_used   = 0;
  int taken_total     = 0;
  int dup_total       = 0;
  int evict_total     = 0;
  int idle_cycles     = 0;
  bit quiet           = 1'b0;

  always #5 clk = ~clk;

  kmv_sketch_update dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),     // [63:0] hash_value
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),     // taken, duplicate, evicted_valid, evicted_value,
                              // fill_count, threshold
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)     // [6:0] k_limit
  );

  // Apply one hash to the sketch model and return the outcome
  function automatic outcome_t sketch_outcome(input logic [HASH_W-1:0] v);
    outcome_t          r;
    int                n;
    int                k;
    logic              dup;
    logic              found;
    logic [HASH_W-1:0] top;
    r     = '0;
    n     = held_count;
    dup   = 1'b0;
    found = 1'b0;
    top   = '0;
    k     = (k_setting == 0) ? 1 : ((k_setting > KMV_MAX_K) ? KMV_MAX_K : int'(k_setting));
    for (int i = 0; i < n; i++)
      if (held[i] == v) dup = 1'b1;
    if (!dup) begin
      if (n < k) begin
        held[n] = v;
        n++;
        if (n == 1 || v > held_max) held_max = v;
        r.taken = 1'b1;
      end else if (n > 0 && v < held_max) begin
        // overwrite the slot holding the max, then rescan for the new max
        for (int i = 0; i < n; i++) begin
          if (!found && held[i] == held_max) begin
            held[i] = v;
            found   = 1'b1;
          end
        end
        for (int i = 0; i < n; i++)
          if (held[i] > top) top = held[i];
        r.evicted_valid = 1'b1;
        r.evicted_value = held_max;
        held_max        = top;
        r.taken         = 1'b1;
      end
    end
    held_count   = n;
    r.duplicate  = dup;
    r.fill_count = FILL_W'(n);
    r.threshold  = (n == 0) ? '0 : held_max;
    taken_total += r.taken;
    dup_total   += r.duplicate;
    evict_total += r.evicted_valid;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [HASH_W-1:0] want,
                             input logic [HASH_W-1:0] got);
    if (want !== got) begin
      if (mismatch_count < 10)
        $display("MISMATCH result %0d %s: expected %h, got %h",
                 results_seen, name, want, got);
      mismatch_count++;
    end
  endtask

  // Driver: predicts on each accepted hash, loads the next one when free
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) k_setting = cfg_data;
      if (s_tvalid && s_tready) begin
        outcome_queue.insert(outcome_queue.size(), sketch_outcome(s_tdata));
        hashes_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (hash_queue.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= hash_queue.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compare each result transaction
  always @(posedge clk) begin : result_monitor
    outcome_t want;
    outcome_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (outcome_queue.size() == 0) begin
          if (mismatch_count < 10)
            $display("MISMATCH: result %0d arrived with nothing predicted, data %h",
                     results_seen, m_tdata);
          mismatch_count++;
        end else begin
          want = outcome_queue.pop_front();
          got  = m_tdata[RES_W-1:0];
          check_field("taken",         64'(want.taken),         64'(got.taken));
          check_field("duplicate",     64'(want.duplicate),     64'(got.duplicate));
          check_field("evicted_valid", 64'(want.evicted_valid), 64'(got.evicted_valid));
          check_field("evicted_value", want.evicted_value,      got.evicted_value);
          check_field("fill_count",    64'(want.fill_count),    64'(got.fill_count));
          check_field("threshold",     want.threshold,          got.threshold);
          check_field("padding",       '0,                      64'(m_tdata[RES_BW-1:RES_W]));
        end
      end
    end
  end

  // Watchdog: stop if no transaction moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // Keep the pending queue short so value hints track the sketch
  task automatic queue_hash(input logic [HASH_W-1:0] v);
    while (hash_queue.size() >= 2) @(posedge clk);
    hash_queue.insert(hash_queue.size(), v);
    hashes_queued++;
    sent_history.insert(sent_history.size(), v);
    if (sent_history.size() > HISTORY_DEPTH) void'(sent_history.pop_front());
  endtask

  // Sender holds off until every predicted result has come back
  task automatic drain_sketch();
    do @(posedge clk);
    while (hashes_accepted != hashes_queued || outcome_queue.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_k_limit(input logic [KLIM_W-1:0] k);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Mix of fresh values, repeats, values near the threshold, log-scaled values and tiny values
  function automatic logic [HASH_W-1:0] pick_hash();
    int unsigned       sel;
    logic [HASH_W-1:0] v;
    sel = $urandom_range(99);
    if (sel < 30)
      v = {$urandom, $urandom};
    else if (sel < 55 && sent_history.size() != 0)
      v = sent_history[$urandom_range(sent_history.size() - 1)];
    else if (sel < 65 && held_count > 0)
      v = $urandom_range(1) ? held_max : held[$urandom_range(held_count - 1)];
    else if (sel < 75 && held_count > 0)
      v = $urandom_range(1) ? held_max + 64'd1 : held_max - 64'd1;
    else if (sel < 95)
      v = {$urandom, $urandom} >> $urandom_range(63);
    else
      v = 64'($urandom_range(3));
    return v;
  endfunction

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) queue_hash(pick_hash());
  endtask

  initial begin
    int k_plan[$];
    k_plan = '{10, 20, 127, 64, 33};
    repeat (4) k_plan.insert(k_plan.size(), $urandom_range(127));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Default k: extremes, repeats of both, assorted bit patterns
    queue_hash(64'h0);
    queue_hash('1);
    queue_hash(64'h0);
    queue_hash('1);
    queue_hash(64'h1);
    queue_hash(64'h8000_0000_0000_0000);
    queue_hash(64'h7FFF_FFFF_FFFF_FFFF);
    queue_hash(64'hFFFF_FFFF_FFFF_FFFE);
    queue_hash(64'hAAAA_AAAA_AAAA_AAAA);
    queue_hash(64'h5555_5555_5555_5555);
    queue_random(RAND_PER_PHASE);
    drain_sketch();

    // k lowered below the fill: sketch acts full and only replaces its max
    write_k_limit(KLIM_W'(1));
    queue_hash(held_max);
    queue_hash(64'h1234);
    queue_hash(64'hFFFF_FFFF);
    queue_hash('1);
    queue_hash(64'hAAAA_AAAA_AAAA_AAAA);
    queue_hash(64'h0);
    queue_random(RAND_PER_PHASE);
    drain_sketch();

    // k of zero behaves as one
    write_k_limit(KLIM_W'(0));
    queue_hash('1);
    queue_hash(64'h2);
    queue_random(RAND_PER_PHASE);
    drain_sketch();

    // Rising, falling, saturated and random k settings; phases with k of 127 run without idling
    foreach (k_plan[p]) begin
      write_k_limit(KLIM_W'(k_plan[p]));
      quiet = (k_plan[p] == 127);
      queue_random(RAND_PER_PHASE);
      drain_sketch();
      quiet = 1'b0;
    end

    $display("Summary: %0d hashes under %0d k settings, %0d entered, %0d repeats, %0d evictions",
             hashes_accepted, settings_used + 1, taken_total, dup_total, evict_total);
    $display("Summary: final fill %0d, %0d results checked", held_count, results_seen);
    if (mismatch_count == 0 && outcome_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
